// ----- rtl/mts_pkg.sv -----
`default_nettype none

package mts_pkg;

  localparam int MONTH_BINS = 12;
  localparam int AVG_SUM_W  = 20;   // sum of twelve Q8.8 averages
  localparam int IN_W       = 16;
  localparam int OUT_W      = 72;

  // year mean: (mag + 6) / 12 = (((mag + 6) >> 2) * 43691) >> 17, exact while
  // the quarter stays below 2^17
  localparam int          YEAR_RECIP_SH = 17;
  localparam logic [16:0] YEAR_RECIP    = 17'd43691;

  localparam logic [3:0] YEAR_ROW   = 4'd12;
  localparam logic       OP_RECORD  = 1'b0;
  localparam logic       OP_REPORT  = 1'b1;

  localparam logic signed [7:0] EMPTY_LOW  = 8'sd100;
  localparam logic signed [7:0] EMPTY_HIGH = -8'sd100;

  typedef struct packed {
    logic       rec_we;
    logic       yr_clear;
    logic       prep;
    logic       div_start;
    logic       row_load;
    logic       row_last;
    logic       clear_bins;
    logic [3:0] row;
  } mts_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } mts_stat_t;

endpackage

`default_nettype wire

// ----- rtl/monthly_temperature_statistics.sv -----
// Monthly temperature statistics.
// Input stream: one word per record or report command. in_tuser is the opcode
// (record or report). A record updates its month bin as it is accepted, so
// records stream at one word per clock while no report is in progress and
// produce no output. A report word sweeps the rows: each month row is averaged
// by the shared restoring divider, whose quotient has QW = max(COUNT_BITS + 8 +
// FRACTION_BITS, 20) + 1 bits and forms the rounded average. The year row
// skips the divider, its mean of the twelve averages coming from a reciprocal
// multiply. in_tready is low for the sweep.
// Output stream: one word per row, out_tlast on the last row. Rows sit in an
// output register; a stalled receiver holds the current row and the sweep
// waits for it. Bins clear as the last row is loaded, so new records may be
// taken while that row is still waiting.
// cfg_wr_en writes report_month (0 or 13..15 = all rows plus year, 1..12 = that
// month only); write it only while no report is in progress.
// Reset (rst_n low, synchronous) clears all bins, the selector and the
// output valid flag.
`default_nettype none

module monthly_temperature_statistics #(
  parameter int COUNT_BITS    = 16,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // month[3:0], temperature[11:4], parsed_ok[12]
  input  wire logic        in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // row_index[3:0], value_count[19:4],
                                       // error_count[35:20], average_q8[51:36],
                                       // minimum[59:52], maximum[67:60]
  output logic             out_tlast,  // last_row
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data // report_month
);

  mts_pkg::mts_cmd_t  cmd;
  mts_pkg::mts_stat_t stat;

  mts_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tuser    (in_tuser),
    .in_tready   (in_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stat        (stat),
    .cmd         (cmd)
  );

  mts_datapath #(
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/mts_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle. Rounds to nearest by
// adding half the divisor to the dividend at load.
module mts_div #(
  parameter int DVD_W = 32,
  parameter int DVS_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic [DVD_W:0]        quotient
);

  localparam int QW    = DVD_W + 1;
  localparam int CNT_W = $clog2(QW + 1);

  logic [QW-1:0]    acc_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           fits;

  assign trial = {rem_r, acc_r[QW-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(QW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= QW'(dividend) + QW'(divisor >> 1);
      rem_r <= '0;
      den_r <= divisor;
    end else if (cnt_r != '0) begin
      acc_r <= {acc_r[QW-2:0], fits};
      rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign busy     = cnt_r != '0;
  assign quotient = acc_r;

endmodule

`default_nettype wire

// ----- rtl/mts_datapath.sv -----
`default_nettype none

module mts_datapath #(
  parameter int COUNT_BITS    = 16,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mts_pkg::mts_cmd_t        cmd,
  output mts_pkg::mts_stat_t            stat,
  input  wire logic [mts_pkg::IN_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [mts_pkg::OUT_W-1:0]     out_tdata,
  output logic                          out_tlast
);

  localparam int SUM_W = COUNT_BITS + 8;
  localparam int MAG_W = (SUM_W + FRACTION_BITS > mts_pkg::AVG_SUM_W) ?
                         SUM_W + FRACTION_BITS : mts_pkg::AVG_SUM_W;
  localparam int QW    = MAG_W + 1;
  localparam int TOT_W = COUNT_BITS + 4;
  localparam int SAT_W = (TOT_W > 16) ? TOT_W : 17;
  localparam int AS_W  = mts_pkg::AVG_SUM_W;
  localparam int YP_W  = AS_W - 2 + mts_pkg::YEAR_RECIP_SH;

  function automatic logic [15:0] sat16(input logic [SAT_W-1:0] v);
    sat16 = (v > SAT_W'(17'h0FFFF)) ? 16'hFFFF : v[15:0];
  endfunction

  // month bins
  logic signed [SUM_W-1:0]  bin_sum_r    [mts_pkg::MONTH_BINS];
  logic [COUNT_BITS-1:0]    bin_count_r  [mts_pkg::MONTH_BINS];
  logic [COUNT_BITS-1:0]    bin_errors_r [mts_pkg::MONTH_BINS];
  logic signed [7:0]        bin_low_r    [mts_pkg::MONTH_BINS];
  logic signed [7:0]        bin_high_r   [mts_pkg::MONTH_BINS];

  // record decode
  logic [3:0]              month;
  logic signed [7:0]       temp;
  logic                    parsed_ok;
  logic                    month_ok;
  logic [3:0]              midx;
  logic signed [SUM_W-1:0] cur_sum;
  logic [COUNT_BITS-1:0]   cur_cnt;
  logic [COUNT_BITS-1:0]   cur_err;
  logic signed [7:0]       cur_low;
  logic signed [7:0]       cur_high;

  assign month     = in_tdata[3:0];
  assign temp      = signed'(in_tdata[11:4]);
  assign parsed_ok = in_tdata[12];
  assign month_ok  = month inside {[4'd1:4'd12]};
  assign midx      = month - 4'd1;
  assign cur_sum   = bin_sum_r[midx];
  assign cur_cnt   = bin_count_r[midx];
  assign cur_err   = bin_errors_r[midx];
  assign cur_low   = bin_low_r[midx];
  assign cur_high  = bin_high_r[midx];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_bins) begin
      for (int i = 0; i < mts_pkg::MONTH_BINS; i++) begin
        bin_sum_r[i]    <= '0;
        bin_count_r[i]  <= '0;
        bin_errors_r[i] <= '0;
        bin_low_r[i]    <= mts_pkg::EMPTY_LOW;
        bin_high_r[i]   <= mts_pkg::EMPTY_HIGH;
      end
    end else if (cmd.rec_we && month_ok) begin
      if (!parsed_ok) begin
        if (cur_err != '1) begin
          bin_errors_r[midx] <= cur_err + 1'b1;
        end
      end else begin
        // first valid word of a bin sets both extremes
        if (cur_cnt == '0) begin
          bin_low_r[midx]  <= temp;
          bin_high_r[midx] <= temp;
        end else begin
          if (temp < cur_low) begin
            bin_low_r[midx] <= temp;
          end
          if (temp > cur_high) begin
            bin_high_r[midx] <= temp;
          end
        end
        if (cur_cnt != '1) begin
          bin_sum_r[midx]   <= cur_sum + SUM_W'(temp);
          bin_count_r[midx] <= cur_cnt + 1'b1;
        end
      end
    end
  end

  // report row read
  logic                    is_year;
  logic [3:0]              rix;
  logic signed [SUM_W-1:0] rd_sum;
  logic [COUNT_BITS-1:0]   rd_cnt;
  logic [COUNT_BITS-1:0]   rd_err;
  logic signed [7:0]       rd_low;
  logic signed [7:0]       rd_high;

  assign is_year = cmd.row == mts_pkg::YEAR_ROW;
  assign rix     = is_year ? 4'd0 : cmd.row;
  assign rd_sum  = bin_sum_r[rix];
  assign rd_cnt  = bin_count_r[rix];
  assign rd_err  = bin_errors_r[rix];
  assign rd_low  = bin_low_r[rix];
  assign rd_high = bin_high_r[rix];

  // year accumulators
  logic [TOT_W-1:0]       tot_cnt_r;
  logic [TOT_W-1:0]       tot_err_r;
  logic signed [AS_W-1:0] avg_sum_r;
  logic signed [7:0]      yr_low_r;
  logic signed [7:0]      yr_high_r;
  logic                   yr_any_r;

  // divider operands
  logic [MAG_W-1:0]      mag_r;
  logic [COUNT_BITS-1:0] den_r;
  logic                  neg_r;
  logic                  zero_r;
  logic [SUM_W-1:0]      abs_sum;
  logic [AS_W-1:0]       abs_avg;
  logic                  div_busy;
  logic [QW-1:0]         quot;

  assign abs_sum = rd_sum[SUM_W-1] ? SUM_W'(-rd_sum) : SUM_W'(rd_sum);
  assign abs_avg = avg_sum_r[AS_W-1] ? AS_W'(-avg_sum_r) : AS_W'(avg_sum_r);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      if (is_year) begin
        neg_r  <= avg_sum_r[AS_W-1];
        mag_r  <= MAG_W'(abs_avg);
        zero_r <= 1'b0;
      end else begin
        neg_r  <= rd_sum[SUM_W-1];
        mag_r  <= MAG_W'(abs_sum) << FRACTION_BITS;
        den_r  <= rd_cnt;
        zero_r <= rd_cnt == '0;
      end
    end
  end

  mts_div #(
    .DVD_W (MAG_W),
    .DVS_W (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mag_r),
    .divisor  (den_r),
    .busy     (div_busy),
    .quotient (quot)
  );

  // year mean of the twelve averages, rounded by the bias of half of twelve
  logic [AS_W-1:0] yr_biased;
  logic [AS_W-3:0] yr_quarter;
  logic [YP_W-1:0] yr_prod;
  logic [QW-1:0]   yr_quot;
  logic [QW-1:0]   avg_quot;

  assign yr_biased  = mag_r[AS_W-1:0] + AS_W'(mts_pkg::MONTH_BINS / 2);
  assign yr_quarter = yr_biased[AS_W-1:2];
  assign yr_prod    = yr_quarter * mts_pkg::YEAR_RECIP;
  assign yr_quot    = QW'(yr_prod[YP_W-1:mts_pkg::YEAR_RECIP_SH]);
  assign avg_quot   = is_year ? yr_quot : quot;

  logic signed [15:0] avg_val;

  always_comb begin
    if (zero_r) begin
      avg_val = '0;
    end else if (neg_r) begin
      avg_val = (avg_quot > QW'(32768)) ? 16'sh8000 : signed'(16'(QW'(0) - avg_quot));
    end else begin
      avg_val = (avg_quot > QW'(32767)) ? 16'sh7FFF : signed'(avg_quot[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.yr_clear) begin
      tot_cnt_r <= '0;
      tot_err_r <= '0;
      avg_sum_r <= '0;
      yr_low_r  <= mts_pkg::EMPTY_LOW;
      yr_high_r <= mts_pkg::EMPTY_HIGH;
      yr_any_r  <= 1'b0;
    end else if (cmd.row_load && !is_year) begin
      tot_cnt_r <= tot_cnt_r + TOT_W'(rd_cnt);
      tot_err_r <= tot_err_r + TOT_W'(rd_err);
      avg_sum_r <= avg_sum_r + AS_W'(avg_val);
      if (rd_cnt != '0) begin
        if (!yr_any_r || rd_low < yr_low_r) begin
          yr_low_r <= rd_low;
        end
        if (!yr_any_r || rd_high > yr_high_r) begin
          yr_high_r <= rd_high;
        end
        yr_any_r <= 1'b1;
      end
    end
  end

  // row fields
  logic [15:0]       row_cnt;
  logic [15:0]       row_err;
  logic signed [7:0] row_low;
  logic signed [7:0] row_high;

  always_comb begin
    if (is_year) begin
      row_cnt  = sat16(SAT_W'(tot_cnt_r));
      row_err  = sat16(SAT_W'(tot_err_r));
      row_low  = yr_any_r ? yr_low_r : mts_pkg::EMPTY_LOW;
      row_high = yr_any_r ? yr_high_r : mts_pkg::EMPTY_HIGH;
    end else begin
      row_cnt  = sat16(SAT_W'(rd_cnt));
      row_err  = sat16(SAT_W'(rd_err));
      row_low  = rd_low;
      row_high = rd_high;
    end
  end

  // output word register
  logic                     out_valid_r;
  logic [mts_pkg::OUT_W-1:0] out_data_r;
  logic                     out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.row_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      out_data_r <= {4'b0, row_high, row_low, avg_val, row_err, row_cnt, cmd.row};
      out_last_r <= cmd.row_last;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign out_tlast     = out_last_r;
  assign stat.out_free = !out_valid_r || out_tready;
  assign stat.div_busy = div_busy;

endmodule

`default_nettype wire

// ----- rtl/mts_ctrl.sv -----
`default_nettype none

module mts_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_tuser,
  output logic                    in_tready,
  input  wire logic               cfg_wr_en,
  input  wire logic [3:0]         cfg_wr_data,
  input  wire mts_pkg::mts_stat_t stat,
  output mts_pkg::mts_cmd_t       cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_LOAD  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] row_r, row_nxt;
  logic       single_r, single_nxt;
  logic [3:0] rpt_month_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      single_r    <= 1'b0;
      rpt_month_r <= '0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      single_r <= single_nxt;
      if (cfg_wr_en) begin
        rpt_month_r <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.row    = row_r;
    in_tready  = state_r == ST_IDLE;
    state_nxt  = state_r;
    row_nxt    = row_r;
    single_nxt = single_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == mts_pkg::OP_RECORD) begin
            cmd.rec_we = 1'b1;
          end else begin
            cmd.yr_clear = 1'b1;
            // out-of-range selector reports the full year
            if (rpt_month_r inside {[4'd1:4'd12]}) begin
              single_nxt = 1'b1;
              row_nxt    = rpt_month_r - 4'd1;
            end else begin
              single_nxt = 1'b0;
              row_nxt    = 4'd0;
            end
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        // year mean comes from a multiply, no divide pass
        state_nxt = (row_r == mts_pkg::YEAR_ROW) ? ST_LOAD : ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (stat.out_free) begin
          cmd.row_load = 1'b1;
          cmd.row_last = single_r || row_r == mts_pkg::YEAR_ROW;
          if (cmd.row_last) begin
            cmd.clear_bins = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            row_nxt   = row_r + 4'd1;
            state_nxt = ST_PREP;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mts_checker.sv -----
`default_nettype none

module mts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata,
  input wire logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_year_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] == 4'd12 |-> out_tlast)
    else $error("year row not marked last");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19:4] != 16'd0 |->
      $signed(out_tdata[59:52]) <= $signed(out_tdata[67:60]))
    else $error("minimum above maximum in non-empty row");

  a_empty_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] != 4'd12 && out_tdata[19:4] == 16'd0 |->
      out_tdata[51:36] == 16'd0 && out_tdata[59:52] == 8'd100 &&
      out_tdata[67:60] == 8'h9C)
    else $error("empty month row not at sentinel values");

endmodule

bind monthly_temperature_statistics mts_checker u_mts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
